FILE: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared widths, register indexes, reset values and types of the touch
// coordinate filter
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int DATA_W       = 12;
  localparam int WINDOW_DEPTH = 5;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W        = DATA_W + CNT_W;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int DIV_CNT_W    = $clog2(PROD_W + 1);
  localparam int REG_IDX_W    = 3;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

  localparam logic [REG_IDX_W-1:0] REG_CAL_X_MIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAL_X_MAX     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL_Y_MIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAL_Y_MAX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SWAP_AXES     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_AXES   = 3'd7;

  localparam logic [DATA_W-1:0] RST_CAL_X_MIN     = 12'd250;
  localparam logic [DATA_W-1:0] RST_CAL_X_MAX     = 12'd3875;
  localparam logic [DATA_W-1:0] RST_CAL_Y_MIN     = 12'd425;
  localparam logic [DATA_W-1:0] RST_CAL_Y_MAX     = 12'd3825;
  localparam logic [DATA_W-1:0] RST_SCREEN_WIDTH  = 12'd480;
  localparam logic [DATA_W-1:0] RST_SCREEN_HEIGHT = 12'd320;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_SHIFT,
    S_SUM,
    S_AVG_START,
    S_AVG_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic [IDX_W-1:0] idx;
  } win_ctl_t;

endpackage

FILE: rtl/tcf_in_if.sv
// ----------------------------------------------------------------------------
// tcf_in_if
// Raw touch sample channel: valid/ready with x, y and pressure
// ----------------------------------------------------------------------------
interface tcf_in_if;
  import tcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] raw_x;
  logic [DATA_W-1:0] raw_y;
  logic [DATA_W-1:0] pressure;

  modport source (output valid, output raw_x, output raw_y, output pressure, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input pressure, output ready);

endinterface

FILE: rtl/tcf_out_if.sv
// ----------------------------------------------------------------------------
// tcf_out_if
// Filtered touch coordinate channel: valid/ready with x, y and touch flag
// ----------------------------------------------------------------------------
interface tcf_out_if;
  import tcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] touch_x;
  logic [DATA_W-1:0] touch_y;
  logic              touch_valid;

  modport source (output valid, output touch_x, output touch_y, output touch_valid,
                  input ready);
  modport sink   (input valid, input touch_x, input touch_y, input touch_valid,
                  output ready);

endinterface

FILE: rtl/tcf_div.sv
// ----------------------------------------------------------------------------
// tcf_div
// Shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tcf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tcf_pkg::PROD_W-1:0]   dividend,
  input  logic [tcf_pkg::DATA_W-1:0]   divisor,
  output logic [tcf_pkg::PROD_W-1:0]   quotient,
  output logic                         done
);
  import tcf_pkg::*;

  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dvs;
  logic [PROD_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem, quo[PROD_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/tcf_window.sv
// ----------------------------------------------------------------------------
// tcf_window
// Moving average window: newest sample at entry 0, fill count, one read port
// ----------------------------------------------------------------------------
module tcf_window (
  input  logic                       clk,
  input  logic                       rst,
  input  tcf_pkg::win_ctl_t          ctl,
  input  logic [tcf_pkg::DATA_W-1:0] push_x,
  input  logic [tcf_pkg::DATA_W-1:0] push_y,
  output logic [tcf_pkg::DATA_W-1:0] rd_x,
  output logic [tcf_pkg::DATA_W-1:0] rd_y,
  output logic [tcf_pkg::CNT_W-1:0]  count
);
  import tcf_pkg::*;

  logic [DATA_W-1:0] win_x [WINDOW_DEPTH];
  logic [DATA_W-1:0] win_y [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push && count != DEPTH_CNT) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
        win_x[i] <= win_x[i-1];
        win_y[i] <= win_y[i-1];
      end
      win_x[0] <= push_x;
      win_y[0] <= push_y;
    end
  end

  assign rd_x = win_x[ctl.idx];
  assign rd_y = win_y[ctl.idx];

endmodule

FILE: rtl/touch_coordinate_filter_core.sv
// ----------------------------------------------------------------------------
// touch_coordinate_filter_core
// Calibrates raw resistive touch samples and smooths them with a moving
// average over the most recent samples of the current touch.
//
// Channels: sample (raw_x, raw_y, pressure) in, result (touch_x, touch_y,
// touch_valid) out, both valid/ready; one result per sample transfer.
// Configuration: cfg_we/cfg_idx/cfg_data write the calibration registers,
// to be done only while no sample is in flight.
// Sequence: a touch sample passes four times through the shared divider
// (two scalings, two averages), with the window entries summed between the
// scalings and the averages. A release sample (pressure zero) clears the
// window and goes straight to the result. One sample is in work at a time.
// The result sits in an output register: a new sample is taken while it
// waits, and if the receiver stalls the sequencer holds its finished
// result until the output register frees up.
// Reset: calibration registers return to their defaults, the window is
// empty and the held coordinates are zero.
// ----------------------------------------------------------------------------
module touch_coordinate_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcf_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [tcf_pkg::DATA_W-1:0]    cfg_data,
  tcf_in_if.sink                        sample,
  tcf_out_if.source                     result
);
  import tcf_pkg::*;

  // configuration
  logic [DATA_W-1:0] cal_x_min, cal_x_max, cal_y_min, cal_y_max;
  logic [DATA_W-1:0] screen_width, screen_height;
  logic              swap_axes;
  logic [1:0]        invert_axes;

  state_t state, state_next;

  logic              axis;
  logic              touched;
  logic [DATA_W-1:0] vx, vy, cx, cy;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] span_r;
  logic [IDX_W-1:0]  idx;
  logic [SUM_W-1:0]  sum_x, sum_y;
  logic [DATA_W-1:0] held_x, held_y;
  logic              res_valid;
  logic [DATA_W-1:0] res_x, res_y;
  logic              res_touch;

  logic [DATA_W-1:0] v, lo, hi, size, off, span, sat, scaled;
  logic              inv;
  logic              sum_last;
  logic              out_free;

  win_ctl_t          win_ctl;
  logic [DATA_W-1:0] rd_x, rd_y;
  logic [CNT_W-1:0]  win_count;

  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [PROD_W-1:0] div_quo;
  logic              div_done;

  tcf_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (win_ctl),
    .push_x (cx),
    .push_y (cy),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .count  (win_count)
  );

  tcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x_min     <= RST_CAL_X_MIN;
      cal_x_max     <= RST_CAL_X_MAX;
      cal_y_min     <= RST_CAL_Y_MIN;
      cal_y_max     <= RST_CAL_Y_MAX;
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      swap_axes     <= 1'b0;
      invert_axes   <= 2'b00;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CAL_X_MIN:     cal_x_min     <= cfg_data;
        REG_CAL_X_MAX:     cal_x_max     <= cfg_data;
        REG_CAL_Y_MIN:     cal_y_min     <= cfg_data;
        REG_CAL_Y_MAX:     cal_y_max     <= cfg_data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_SWAP_AXES:     swap_axes     <= cfg_data[0];
        REG_INVERT_AXES:   invert_axes   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // per-axis calibration operands
  always_comb begin
    v      = axis ? vy : vx;
    lo     = axis ? cal_y_min : cal_x_min;
    hi     = axis ? cal_y_max : cal_x_max;
    size   = axis ? screen_height : screen_width;
    inv    = axis ? invert_axes[1] : invert_axes[0];
    off    = (v > lo) ? (v - lo) : '0;
    span   = (hi > lo) ? (hi - lo) : DATA_W'(1);
    sat    = (div_quo > PROD_W'(size)) ? size : div_quo[DATA_W-1:0];
    scaled = inv ? (size - sat) : sat;
  end

  assign sum_last = (CNT_W'(idx) + CNT_W'(1)) == win_count;
  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    win_ctl      = '0;
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = span_r;
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          if (sample.pressure == '0) begin
            win_ctl.clear = 1'b1;
            state_next    = S_DONE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = axis ? S_SHIFT : S_MUL;
        end
      end
      S_SHIFT: begin
        win_ctl.push = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        win_ctl.idx = idx;
        if (sum_last) begin
          state_next = S_AVG_START;
        end
      end
      S_AVG_START: begin
        div_start    = 1'b1;
        div_dividend = PROD_W'(axis ? sum_y : sum_x);
        div_divisor  = DATA_W'(win_count);
        state_next   = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          state_next = axis ? S_DONE : S_AVG_START;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis      <= 1'b0;
      touched   <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            // x is mirrored: 4095 - raw_x
            vx      <= swap_axes ? sample.raw_y : ~sample.raw_x;
            vy      <= swap_axes ? ~sample.raw_x : sample.raw_y;
            axis    <= 1'b0;
            touched <= sample.pressure != '0;
          end
        end
        S_MUL: begin
          prod   <= PROD_W'(off) * PROD_W'(size);
          span_r <= span;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (axis) begin
              cy <= scaled;
            end else begin
              cx <= scaled;
            end
            axis <= ~axis;
          end
        end
        S_SHIFT: begin
          sum_x <= '0;
          sum_y <= '0;
          idx   <= '0;
        end
        S_SUM: begin
          sum_x <= sum_x + SUM_W'(rd_x);
          sum_y <= sum_y + SUM_W'(rd_y);
          idx   <= idx + IDX_W'(1);
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            if (axis) begin
              held_y <= div_quo[DATA_W-1:0];
            end else begin
              held_x <= div_quo[DATA_W-1:0];
            end
            axis <= ~axis;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      res_x     <= held_x;
      res_y     <= held_y;
      res_touch <= touched && (win_count >= CNT_W'(2));
    end
  end

  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.touch_x     = res_x;
  assign result.touch_y     = res_y;
  assign result.touch_valid = res_touch;

endmodule
